FILE: hw/rtl/crb_pkg.sv
// ----------------------------------------------------------------------------
// crb_pkg
// Shared types, codes and the CRC-32/BZIP2 byte step for the CRC checked
// block receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crb_pkg;

    localparam int unsigned CNT_W     = 33;
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(16);
    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_BODY   = 2'd1,
        OP_CANCEL = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_TRANSFER_TYPE = 2'd0,
        REG_TOTAL_SIZE    = 2'd1,
        REG_RESUME_OFFSET = 2'd2,
        REG_NONE          = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_BLOCK_OK      = 4'd0,
        ST_DONE          = 4'd1,
        ST_SHORT         = 4'd2,
        ST_BAD_TYPE      = 4'd3,
        ST_BAD_LENGTH    = 4'd4,
        ST_CRC           = 4'd5,
        ST_COMMIT_REFUSE = 4'd6,
        ST_STARTED       = 4'd7,
        ST_START_DONE    = 4'd8,
        ST_START_REFUSE  = 4'd9,
        ST_CANCELLED     = 4'd10
    } status_t;

    typedef enum logic [2:0] {
        CMD_START,
        CMD_START_REFUSED,
        CMD_CANCEL,
        CMD_BLOCK_FAIL,
        CMD_BLOCK
    } cmd_kind_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       last;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic        block_type;
        logic [31:0] sequence_res;
        logic [31:0] payload_len;
        logic [31:0] received_count;
        logic        transfer_done;
    } out_t;

    // For a start request, seq carries the total size and len the resume offset.
    typedef struct packed {
        cmd_kind_t   kind;
        status_t     status;
        logic        typ;
        logic [31:0] seq;
        logic [31:0] len;
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/crb_front.sv
// ----------------------------------------------------------------------------
// crb_front
// Accepts requests, assembles block headers, runs the payload CRC and
// classifies each block end into a command for the commit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire crb_pkg::in_t   item,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output logic                cmd_push,
    output crb_pkg::cmd_t       cmd
);
    import crb_pkg::*;

    logic             xfer_type_reg;
    logic [31:0]      total_size_reg;
    logic [31:0]      resume_reg;

    logic [CNT_W-1:0] body_count_reg, body_count_next;
    logic [31:0]      word_shift_reg, word_shift_next;
    logic [31:0]      hdr_type_reg, hdr_type_next;
    logic [31:0]      hdr_crc_reg, hdr_crc_next;
    logic [31:0]      hdr_seq_reg, hdr_seq_next;
    logic [31:0]      hdr_len_reg, hdr_len_next;
    logic [31:0]      crc_reg, crc_next;

    // Body state after taking the current byte, before any end-of-block clear.
    logic [CNT_W-1:0] st_count;
    logic [31:0]      st_shift, st_type, st_crcw, st_seq, st_len, st_crc;
    logic             in_hdr;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            xfer_type_reg  <= 1'b0;
            total_size_reg <= '0;
            resume_reg     <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_TRANSFER_TYPE: xfer_type_reg  <= cfg_data[0];
                REG_TOTAL_SIZE:    total_size_reg <= cfg_data;
                REG_RESUME_OFFSET: resume_reg     <= cfg_data;
                REG_NONE:          ;
            endcase
        end
    end

    always_comb begin
        in_hdr   = body_count_reg < HDR_BYTES;
        st_shift = word_shift_reg;
        st_type  = hdr_type_reg;
        st_crcw  = hdr_crc_reg;
        st_seq   = hdr_seq_reg;
        st_len   = hdr_len_reg;
        st_crc   = crc_reg;
        if (in_hdr) begin
            st_shift = {word_shift_reg[23:0], item.data_byte};
            if (body_count_reg[1:0] == 2'd3) begin
                unique case (body_count_reg[3:2])
                    2'd0: st_type = st_shift;
                    2'd1: st_crcw = st_shift;
                    2'd2: st_seq  = st_shift;
                    2'd3: st_len  = st_shift;
                endcase
            end
        end else begin
            st_crc = crc_byte(crc_reg, item.data_byte);
        end
        st_count = (body_count_reg != CNT_MAX) ? body_count_reg + CNT_W'(1)
                                               : body_count_reg;
    end

    always_comb begin
        body_count_next = body_count_reg;
        word_shift_next = word_shift_reg;
        hdr_type_next   = hdr_type_reg;
        hdr_crc_next    = hdr_crc_reg;
        hdr_seq_next    = hdr_seq_reg;
        hdr_len_next    = hdr_len_reg;
        crc_next        = crc_reg;
        cmd_push        = 1'b0;
        cmd.kind        = CMD_CANCEL;
        cmd.status      = ST_CANCELLED;
        cmd.typ         = 1'b0;
        cmd.seq         = '0;
        cmd.len         = '0;
        if (fire) begin
            unique case (item.op)
                OP_START: begin
                    cmd_push = 1'b1;
                    if (total_size_reg == '0 || resume_reg > total_size_reg) begin
                        cmd.kind   = CMD_START_REFUSED;
                        cmd.status = ST_START_REFUSE;
                    end else begin
                        cmd.kind = CMD_START;
                        cmd.typ  = xfer_type_reg;
                        cmd.seq  = total_size_reg;
                        cmd.len  = resume_reg;
                        body_count_next = '0;
                        word_shift_next = '0;
                        hdr_type_next   = '0;
                        hdr_crc_next    = '0;
                        hdr_seq_next    = '0;
                        hdr_len_next    = '0;
                        crc_next        = CRC_INIT;
                    end
                end
                OP_CANCEL: begin
                    cmd_push        = 1'b1;
                    body_count_next = '0;
                    word_shift_next = '0;
                    hdr_type_next   = '0;
                    hdr_crc_next    = '0;
                    hdr_seq_next    = '0;
                    hdr_len_next    = '0;
                    crc_next        = CRC_INIT;
                end
                OP_BODY: begin
                    if (!item.last) begin
                        body_count_next = st_count;
                        word_shift_next = st_shift;
                        hdr_type_next   = st_type;
                        hdr_crc_next    = st_crcw;
                        hdr_seq_next    = st_seq;
                        hdr_len_next    = st_len;
                        crc_next        = st_crc;
                    end else begin
                        cmd_push = 1'b1;
                        cmd.kind = CMD_BLOCK_FAIL;
                        cmd.typ  = st_type[0];
                        cmd.seq  = st_seq;
                        cmd.len  = st_len;
                        if (st_count < HDR_BYTES) begin
                            cmd.status = ST_SHORT;
                            cmd.typ    = 1'b0;
                            cmd.seq    = '0;
                            cmd.len    = '0;
                        end else if (st_type > 32'd1) begin
                            cmd.status = ST_BAD_TYPE;
                            cmd.typ    = 1'b0;
                        end else if (st_len == '0 ||
                                     {1'b0, st_len} != st_count - HDR_BYTES) begin
                            cmd.status = ST_BAD_LENGTH;
                        end else if ((st_crc ^ CRC_INIT) != st_crcw) begin
                            cmd.status = ST_CRC;
                        end else begin
                            cmd.kind   = CMD_BLOCK;
                            cmd.status = ST_BLOCK_OK;
                        end
                        body_count_next = '0;
                        word_shift_next = '0;
                        hdr_type_next   = '0;
                        hdr_crc_next    = '0;
                        hdr_seq_next    = '0;
                        hdr_len_next    = '0;
                        crc_next        = CRC_INIT;
                    end
                end
                OP_UNUSED: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            body_count_reg <= '0;
            word_shift_reg <= '0;
            hdr_type_reg   <= '0;
            hdr_crc_reg    <= '0;
            hdr_seq_reg    <= '0;
            hdr_len_reg    <= '0;
            crc_reg        <= CRC_INIT;
        end else begin
            body_count_reg <= body_count_next;
            word_shift_reg <= word_shift_next;
            hdr_type_reg   <= hdr_type_next;
            hdr_crc_reg    <= hdr_crc_next;
            hdr_seq_reg    <= hdr_seq_next;
            hdr_len_reg    <= hdr_len_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crb_cmd_queue.sv
// ----------------------------------------------------------------------------
// crb_cmd_queue
// Two-entry queue of commands between the front and the commit stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire crb_pkg::cmd_t  din,
    output logic                full,
    input  wire logic           pop,
    output crb_pkg::cmd_t       dout,
    output logic                empty
);
    import crb_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crb_commit.sv
// ----------------------------------------------------------------------------
// crb_commit
// Holds the transfer state, carries out start, cancel and block commit
// commands, and queues the results for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module crb_commit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire crb_pkg::cmd_t  cmd,
    input  wire logic           cmd_empty,
    output logic                cmd_pop,
    output crb_pkg::out_t       result,
    output logic                empty,
    input  wire logic           pop
);
    import crb_pkg::*;

    logic        active_reg, active_next;
    logic        complete_reg, complete_next;
    logic        atype_reg, atype_next;
    logic [31:0] received_reg, received_next;
    logic [31:0] held_reg, held_next;

    out_t        res_entry_reg [2];
    logic        res_wr_reg, res_rd_reg;
    logic [1:0]  res_count_reg;
    out_t        res;
    logic [31:0] room;
    logic [31:0] sum;
    logic        res_pop;

    assign cmd_pop = !cmd_empty && (res_count_reg != 2'd2);
    assign room    = held_reg - received_reg;
    assign sum     = received_reg + cmd.len;

    always_comb begin
        active_next   = active_reg;
        complete_next = complete_reg;
        atype_next    = atype_reg;
        received_next = received_reg;
        held_next     = held_reg;
        res.status    = cmd.status;
        res.block_type   = 1'b0;
        res.sequence_res = '0;
        res.payload_len  = '0;
        unique case (cmd.kind)
            CMD_START: begin
                active_next   = cmd.len != cmd.seq;
                complete_next = cmd.len == cmd.seq;
                atype_next    = cmd.typ;
                held_next     = cmd.seq;
                received_next = cmd.len;
                res.status    = (cmd.len == cmd.seq) ? ST_START_DONE : ST_STARTED;
            end
            CMD_START_REFUSED: begin
                res.status = ST_START_REFUSE;
            end
            CMD_CANCEL: begin
                active_next   = 1'b0;
                complete_next = 1'b0;
                atype_next    = 1'b0;
                received_next = '0;
                held_next     = '0;
                res.status    = ST_CANCELLED;
            end
            CMD_BLOCK_FAIL: begin
                res.block_type   = cmd.typ;
                res.sequence_res = cmd.seq;
                res.payload_len  = cmd.len;
            end
            CMD_BLOCK: begin
                res.block_type   = cmd.typ;
                res.sequence_res = cmd.seq;
                res.payload_len  = cmd.len;
                if (!active_reg || complete_reg || atype_reg != cmd.typ ||
                    cmd.len > room) begin
                    res.status = ST_COMMIT_REFUSE;
                end else begin
                    received_next = sum;
                    if (sum == held_reg) begin
                        active_next   = 1'b0;
                        complete_next = 1'b1;
                        res.status    = ST_DONE;
                    end else begin
                        res.status = ST_BLOCK_OK;
                    end
                end
            end
            default: ;
        endcase
        res.received_count = received_next;
        res.transfer_done  = complete_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            active_reg   <= 1'b0;
            complete_reg <= 1'b0;
            atype_reg    <= 1'b0;
            received_reg <= '0;
            held_reg     <= '0;
        end else if (cmd_pop) begin
            active_reg   <= active_next;
            complete_reg <= complete_next;
            atype_reg    <= atype_next;
            received_reg <= received_next;
            held_reg     <= held_next;
        end
    end

    // Result queue: two entries so that a new command can retire while the
    // previous result is still waiting to be taken.
    assign empty   = res_count_reg == 2'd0;
    assign result  = res_entry_reg[res_rd_reg];
    assign res_pop = pop && !empty;

    always_ff @(posedge clk) begin
        if (cmd_pop) begin
            res_entry_reg[res_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_wr_reg    <= 1'b0;
            res_rd_reg    <= 1'b0;
            res_count_reg <= '0;
        end else begin
            if (cmd_pop) begin
                res_wr_reg <= !res_wr_reg;
            end
            if (res_pop) begin
                res_rd_reg <= !res_rd_reg;
            end
            res_count_reg <= res_count_reg + 2'(cmd_pop) - 2'(res_pop);
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/crc_checked_block_receiver.sv
// ----------------------------------------------------------------------------
// crc_checked_block_receiver
// Framed block receiver with header decode and CRC-32/BZIP2 payload check.
// ----------------------------------------------------------------------------
// The receiver takes one request per clock while full is low: start, cancel,
// or one byte of a block body. The front stage decodes the 16-byte header
// and updates the payload CRC one byte per cycle; on the last byte, start or
// cancel it sends a command through a two-entry queue to the commit stage,
// which updates the transfer state and writes one result into a two-entry
// result queue. Requests are taken every cycle as long as results are popped;
// full rises only when both queues are backed up. Body bytes that are not
// last give no result.
// Write the configuration registers only while no request is in flight.
`default_nettype none

module crc_checked_block_receiver (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire crb_pkg::in_t   item,
    output logic                empty,
    input  wire logic           pop,
    output crb_pkg::out_t       result,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);
    import crb_pkg::*;

    logic fire;
    logic cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t cmd_in, cmd_out;

    assign full = cmd_full;
    assign fire = push && !cmd_full;

    crb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    crb_cmd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .din   (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (cmd_out),
        .empty (cmd_empty)
    );

    crb_commit u_commit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
